// ----- hdl/bds_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bds_pkg
// Shared types and constants of the 2x2 box downsampler.
// ----------------------------------------------------------------------------
package bds_pkg;

  localparam int NUM_CH            = 3;
  localparam int SAMPLE_BITS       = 16;
  localparam int PAIR_BITS         = SAMPLE_BITS + 1;
  localparam int RESULT_BITS       = SAMPLE_BITS + 2;
  localparam int DIM_BITS          = 13;
  localparam int ROW_BITS          = 12;
  localparam int MAX_HEIGHT        = 4096;
  localparam int MAX_WIDTH_DEFAULT = 4096;
  localparam int CFG_INDEX_BITS    = 2;
  localparam int CFG_DATA_BITS     = 13;

  localparam logic [DIM_BITS-1:0] FRAME_WIDTH_RESET  = DIM_BITS'(640);
  localparam logic [DIM_BITS-1:0] FRAME_HEIGHT_RESET = DIM_BITS'(480);

  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_AVERAGE_MODE = 2'd2;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample_c0;
    logic [SAMPLE_BITS-1:0] sample_c1;
    logic [SAMPLE_BITS-1:0] sample_c2;
  } pixel_word_t;

  typedef struct packed {
    logic [RESULT_BITS-1:0] result_c0;
    logic [RESULT_BITS-1:0] result_c1;
    logic [RESULT_BITS-1:0] result_c2;
    logic                   end_of_row;
    logic                   end_of_frame;
  } block_word_t;

endpackage
`default_nettype wire

// ----- hdl/bds_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bds_ram
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module bds_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- hdl/box_downsample_2x2.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// box_downsample_2x2
// Raster-order 2x2 box downsampler with sum and rounded-average modes.
// ----------------------------------------------------------------------------
// The block takes one pixel per clock unless stalled and gives one result
// per 2x2 block, registered as its bottom-right pixel is taken. Each pixel
// needs at most one access to the line store (MAX_WIDTH/2 entries of three
// 17-bit pair sums): even rows write a pair sum at each odd column, odd rows
// read it at the even column and use it at the odd one, so the line store
// never holds up a pixel. An output register and a skid word let a pixel be
// taken while a result waits; pixel_stall rises only when both are full.
// The line store is not cleared after reset. Results use the configuration
// in force when the pixel is taken; write it between frames.
module box_downsample_2x2 #(
  parameter int MAX_WIDTH = bds_pkg::MAX_WIDTH_DEFAULT
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 pixel_valid,
  output logic                                      pixel_stall,
  input  wire bds_pkg::pixel_word_t                 pixel_word,
  output logic                                      block_valid,
  input  wire logic                                 block_stall,
  output bds_pkg::block_word_t                      block_word,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [bds_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  wire logic [bds_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  localparam int NUM_CH      = bds_pkg::NUM_CH;
  localparam int SAMPLE_BITS = bds_pkg::SAMPLE_BITS;
  localparam int PAIR_BITS   = bds_pkg::PAIR_BITS;
  localparam int RESULT_BITS = bds_pkg::RESULT_BITS;
  localparam int DIM_BITS    = bds_pkg::DIM_BITS;
  localparam int ROW_BITS    = bds_pkg::ROW_BITS;
  localparam int COL_BITS    = $clog2(MAX_WIDTH);
  localparam int WDIM_BITS   = COL_BITS + 1;
  localparam int CMP_BITS    = (WDIM_BITS > DIM_BITS) ? WDIM_BITS : DIM_BITS;
  localparam int LINE_DEPTH  = MAX_WIDTH / 2;
  localparam int ADDR_BITS   = $clog2(LINE_DEPTH);
  localparam int LINE_BITS   = NUM_CH * PAIR_BITS;

  logic [DIM_BITS-1:0]    frame_width;
  logic [DIM_BITS-1:0]    frame_height;
  logic                   average_mode;

  logic [COL_BITS-1:0]    column_count;
  logic [ROW_BITS-1:0]    row_count;
  logic [SAMPLE_BITS-1:0] left_sample [NUM_CH];

  logic                   skid_valid;
  bds_pkg::block_word_t   skid_word;

  logic [CMP_BITS-1:0]    width_ext;
  logic [WDIM_BITS-1:0]   width_eff;
  logic [WDIM_BITS-1:0]   width_even;
  logic [DIM_BITS-1:0]    height_eff;
  logic [DIM_BITS-1:0]    height_even;
  logic                   active;
  logic                   accept;
  logic                   produce;
  logic                   last_col;
  logic                   last_row;
  logic                   ram_we;
  logic                   ram_re;
  logic [COL_BITS-2:0]    slot;
  logic [LINE_BITS-1:0]   line_wdata;
  logic [LINE_BITS-1:0]   line_rdata;
  logic [SAMPLE_BITS-1:0] sample [NUM_CH];
  logic [RESULT_BITS-1:0] result [NUM_CH];
  bds_pkg::block_word_t   new_word;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= bds_pkg::FRAME_WIDTH_RESET;
      frame_height <= bds_pkg::FRAME_HEIGHT_RESET;
      average_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bds_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data[DIM_BITS-1:0];
        bds_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data[DIM_BITS-1:0];
        bds_pkg::REG_AVERAGE_MODE: average_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    width_ext = CMP_BITS'(frame_width);
    if (width_ext < CMP_BITS'(2)) begin
      width_eff = WDIM_BITS'(2);
    end else if (width_ext > CMP_BITS'(MAX_WIDTH)) begin
      width_eff = WDIM_BITS'(MAX_WIDTH);
    end else begin
      width_eff = width_ext[WDIM_BITS-1:0];
    end
    if (frame_height < DIM_BITS'(2)) begin
      height_eff = DIM_BITS'(2);
    end else if (frame_height > DIM_BITS'(bds_pkg::MAX_HEIGHT)) begin
      height_eff = DIM_BITS'(bds_pkg::MAX_HEIGHT);
    end else begin
      height_eff = frame_height;
    end
  end

  assign width_even  = {width_eff[WDIM_BITS-1:1], 1'b0};
  assign height_even = {height_eff[DIM_BITS-1:1], 1'b0};

  assign sample[0] = pixel_word.sample_c0;
  assign sample[1] = pixel_word.sample_c1;
  assign sample[2] = pixel_word.sample_c2;

  assign accept   = pixel_valid && !pixel_stall;
  assign active   = ({1'b0, column_count} < width_even) && ({1'b0, row_count} < height_even);
  assign produce  = active && column_count[0] && row_count[0];
  assign ram_re   = accept && !column_count[0] && row_count[0];
  assign ram_we   = accept && active && column_count[0] && !row_count[0];
  assign last_col = ({1'b0, column_count} + WDIM_BITS'(1)) >= width_eff;
  assign last_row = ({1'b0, row_count} + DIM_BITS'(1)) >= height_eff;
  assign slot     = column_count[COL_BITS-1:1];

  always_comb begin
    logic [PAIR_BITS-1:0]   pair;
    logic [RESULT_BITS-1:0] total;
    logic [RESULT_BITS-1:0] rounded;
    for (int k = 0; k < NUM_CH; k++) begin
      pair = PAIR_BITS'(left_sample[k]) + PAIR_BITS'(sample[k]);
      line_wdata[k*PAIR_BITS +: PAIR_BITS] = pair;
      total = RESULT_BITS'(line_rdata[k*PAIR_BITS +: PAIR_BITS]) + RESULT_BITS'(pair);
      rounded = (total + RESULT_BITS'(2)) >> 2;
      result[k] = average_mode ? rounded : total;
    end
  end

  always_comb begin
    new_word.result_c0    = result[0];
    new_word.result_c1    = result[1];
    new_word.result_c2    = result[2];
    new_word.end_of_row   = ({1'b0, column_count} == width_even - WDIM_BITS'(1));
    new_word.end_of_frame = new_word.end_of_row &&
                            ({1'b0, row_count} == height_even - DIM_BITS'(1));
  end

  bds_ram #(
    .WIDTH (LINE_BITS),
    .DEPTH (LINE_DEPTH)
  ) u_line (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot[ADDR_BITS-1:0]),
    .wdata (line_wdata),
    .re    (ram_re),
    .raddr (slot[ADDR_BITS-1:0]),
    .rdata (line_rdata)
  );

  always_ff @(posedge clk) begin
    if (accept && active && !column_count[0]) begin
      for (int k = 0; k < NUM_CH; k++) begin
        left_sample[k] <= sample[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (last_col) begin
        column_count <= '0;
        row_count    <= last_row ? '0 : row_count + ROW_BITS'(1);
      end else begin
        column_count <= column_count + COL_BITS'(1);
      end
    end
  end

  assign pixel_stall = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_valid <= 1'b0;
      skid_valid  <= 1'b0;
    end else if (skid_valid) begin
      if (!block_stall) begin
        block_word <= skid_word;
        skid_valid <= 1'b0;
      end
    end else if (accept && produce) begin
      if (block_valid && block_stall) begin
        skid_word  <= new_word;
        skid_valid <= 1'b1;
      end else begin
        block_word  <= new_word;
        block_valid <= 1'b1;
      end
    end else if (!block_stall) begin
      block_valid <= 1'b0;
    end
  end

  // The line store is never read and written in the same cycle.
  assert property (@(posedge clk) disable iff (rst) !(ram_we && ram_re))
    else $error("line store read and write collide");

  // A word waits in the skid stage only behind a word on the output.
  assert property (@(posedge clk) disable iff (rst) skid_valid |-> block_valid)
    else $error("skid word without output word");

  // A result that meets a stalled output lands in the skid stage.
  assert property (@(posedge clk) disable iff (rst)
    (accept && produce && block_valid && block_stall) |=> skid_valid)
    else $error("result lost behind a stalled output");

endmodule
`default_nettype wire
